### design/nfc_codec_pkg.sv
// Shared types, codes and constants for the host frame codec.
// Used by nfc_codec_core, nfc_codec_queue and nfc_host_frame_codec; depends on nothing.
package nfc_codec_pkg;

	localparam int CMD_FRAME_BYTES   = 32;
	localparam int REPLY_FRAME_BYTES = 40;

	// Most results that one input item can cause.
	localparam int MAX_RESULTS = 9;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	localparam logic [7:0] TFI_HOST   = 8'hD4;
	localparam logic [7:0] TFI_READER = 8'hD5;
	localparam logic [7:0] START_CODE = 8'hFF;
	localparam logic [7:0] PREAMBLE   = 8'h00;
	localparam logic [7:0] POSTAMBLE  = 8'h00;
	localparam logic [7:0] LEN_EXTRA  = 8'd2;

	localparam logic [2:0] ACK_LEN = 3'd6;

	// Byte positions within a reply read.
	localparam logic [5:0] RIDX_READY = 6'd0;
	localparam logic [5:0] RIDX_PRE0  = 6'd1;
	localparam logic [5:0] RIDX_PRE1  = 6'd2;
	localparam logic [5:0] RIDX_START = 6'd3;
	localparam logic [5:0] RIDX_LEN   = 6'd4;
	localparam logic [5:0] RIDX_LCS   = 6'd5;
	localparam logic [5:0] RIDX_TFI   = 6'd6;
	localparam logic [5:0] RIDX_CODE  = 6'd7;

	typedef enum logic [1:0] {
		MODE_CMD   = 2'd0,
		MODE_PARAM = 2'd1,
		MODE_ACK   = 2'd2,
		MODE_REPLY = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		KIND_FRAME        = 2'd0,
		KIND_DATA         = 2'd1,
		KIND_REPLY_STATUS = 2'd2,
		KIND_ACK_STATUS   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_BAD_START    = 3'd1,
		ST_BAD_HEADER   = 3'd2,
		ST_OVER_CAP     = 3'd3,
		ST_ACK_MISMATCH = 3'd4,
		ST_TOO_MANY     = 3'd5
	} status_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] data_byte;
		logic [7:0] command_code;
		logic [4:0] param_count;
		logic       frame_start;
		logic [4:0] reply_capacity;
	} item_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] out_byte;
		logic       last;
		status_t    status;
	} res_t;

	typedef struct packed {
		logic [CNT_W-1:0]            count;
		res_t [MAX_RESULTS-1:0]      ent;
	} res_list_t;

	function automatic res_t mk_res(kind_t k, logic [7:0] b, logic l, status_t s);
		res_t r;
		r.kind     = k;
		r.out_byte = b;
		r.last     = l;
		r.status   = s;
		return r;
	endfunction

	// Expected acknowledge frame, one byte per position.
	function automatic logic [7:0] ack_byte(logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd0:    b = 8'h01;
			3'd1:    b = 8'h00;
			3'd2:    b = 8'h00;
			3'd3:    b = 8'hFF;
			3'd4:    b = 8'h00;
			3'd5:    b = 8'hFF;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

### design/nfc_host_frame_codec.sv
// Top level of the host frame codec: input register, protocol core and result register.
// Depends on nfc_codec_pkg, nfc_codec_core and nfc_codec_queue.
//
// Usage:
// The input channel (in_valid, in_stall) carries one byte-level item per transfer:
// a command start, a parameter byte, an acknowledge byte or a reply byte, chosen by mode.
// The output channel (out_valid, out_stall) carries the result items, each with
// kind, out_byte, last and status. One item yields zero to nine results.
// An accepted item is held in the input register; the core processes it
// combinationally and loads its whole result list into the result register,
// which presents the first result. Results leave one per cycle unless stalled.
// Throughput is one item per cycle while each item causes at most one result and
// the receiver does not stall; an item with several results holds the result register
// until its last result leaves, and the next item waits in the input register.
// When the receiver stalls, the head result holds, the result register cannot
// take the next list, and in_stall rises once the input register is occupied.
// Reset clears all protocol state, with no reply read in progress, and empties
// both registers.
module nfc_host_frame_codec (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] mode,
	input  logic [7:0] data_byte,
	input  logic [7:0] command_code,
	input  logic [4:0] param_count,
	input  logic       frame_start,
	input  logic [4:0] reply_capacity,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] kind,
	output logic [7:0] out_byte,
	output logic       last,
	output logic [2:0] status
);
	import nfc_codec_pkg::*;

	logic      valid_s1;
	item_t     item_s1;
	logic      q_ready;
	logic      fire;
	res_list_t res_list;

	assign fire     = valid_s1 && q_ready;
	assign in_stall = valid_s1 && !q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.mode           <= mode;
			item_s1.data_byte      <= data_byte;
			item_s1.command_code   <= command_code;
			item_s1.param_count    <= param_count;
			item_s1.frame_start    <= frame_start;
			item_s1.reply_capacity <= reply_capacity;
		end
	end

	nfc_codec_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.item     (item_s1),
		.res_list (res_list)
	);

	nfc_codec_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire),
		.res_list  (res_list),
		.ready     (q_ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.out_byte  (out_byte),
		.last      (last),
		.status    (status)
	);

endmodule

### design/nfc_codec_core.sv
// Protocol state and the single-pass step that turns one item into its result list.
// Depends on nfc_codec_pkg.
module nfc_codec_core (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    fire,
	input  nfc_codec_pkg::item_t    item,
	output nfc_codec_pkg::res_list_t res_list
);
	import nfc_codec_pkg::*;

	logic [7:0] last_command_q, last_command_nxt;
	logic [7:0] data_sum_q, data_sum_nxt;
	logic [4:0] params_left_q, params_left_nxt;
	logic [2:0] ack_index_q, ack_index_nxt;
	logic       ack_error_q, ack_error_nxt;
	logic [5:0] reply_index_q, reply_index_nxt;
	logic [7:0] reply_length_q, reply_length_nxt;
	logic [4:0] capacity_held_q, capacity_held_nxt;
	logic       reply_done_q, reply_done_nxt;

	mode_t      mode;
	logic [7:0] b;
	logic [7:0] len;
	logic [7:0] sum_new;
	logic [4:0] left_new;
	logic       too_many;
	logic [2:0] aidx;
	logic       aerr;
	logic [5:0] ridx;
	logic       rdone;
	logic [7:0] dl;
	logic       fail;
	status_t    fail_st;

	assign mode     = mode_t'(item.mode);
	assign b        = item.data_byte;
	assign len      = 8'(item.param_count) + LEN_EXTRA;
	assign too_many = (10'(item.param_count) + 10'd9) > 10'(CMD_FRAME_BYTES);
	assign sum_new  = data_sum_q + b;
	assign left_new = params_left_q - 5'd1;
	assign aidx     = item.frame_start ? 3'd0 : ack_index_q;
	assign aerr     = item.frame_start ? 1'b0 : ack_error_q;
	assign ridx     = item.frame_start ? 6'd0 : reply_index_q;
	assign rdone    = item.frame_start ? 1'b0 : reply_done_q;
	assign dl       = reply_length_q - LEN_EXTRA;

	always_comb begin
		last_command_nxt  = last_command_q;
		data_sum_nxt      = data_sum_q;
		params_left_nxt   = params_left_q;
		ack_index_nxt     = ack_index_q;
		ack_error_nxt     = ack_error_q;
		reply_index_nxt   = reply_index_q;
		reply_length_nxt  = reply_length_q;
		capacity_held_nxt = capacity_held_q;
		reply_done_nxt    = reply_done_q;
		res_list          = '0;
		fail              = 1'b0;
		fail_st           = ST_OK;

		case (mode)
			MODE_CMD: begin
				last_command_nxt = item.command_code;
				if (too_many) begin
					params_left_nxt  = '0;
					res_list.ent[0]  = mk_res(KIND_FRAME, 8'h00, 1'b0, ST_TOO_MANY);
					res_list.count   = CNT_W'(1);
				end else begin
					res_list.ent[0] = mk_res(KIND_FRAME, PREAMBLE, 1'b0, ST_OK);
					res_list.ent[1] = mk_res(KIND_FRAME, PREAMBLE, 1'b0, ST_OK);
					res_list.ent[2] = mk_res(KIND_FRAME, START_CODE, 1'b0, ST_OK);
					res_list.ent[3] = mk_res(KIND_FRAME, len, 1'b0, ST_OK);
					res_list.ent[4] = mk_res(KIND_FRAME, 8'h00 - len, 1'b0, ST_OK);
					res_list.ent[5] = mk_res(KIND_FRAME, TFI_HOST, 1'b0, ST_OK);
					res_list.ent[6] = mk_res(KIND_FRAME, item.command_code, 1'b0, ST_OK);
					data_sum_nxt    = TFI_HOST + item.command_code;
					params_left_nxt = item.param_count;
					if (item.param_count == 5'd0) begin
						res_list.ent[7] = mk_res(KIND_FRAME,
							8'h00 - (TFI_HOST + item.command_code), 1'b0, ST_OK);
						res_list.ent[8] = mk_res(KIND_FRAME, POSTAMBLE, 1'b1, ST_OK);
						res_list.count  = CNT_W'(9);
					end else begin
						res_list.count  = CNT_W'(7);
					end
				end
			end
			MODE_PARAM: begin
				if (params_left_q != 5'd0) begin
					data_sum_nxt    = sum_new;
					params_left_nxt = left_new;
					res_list.ent[0] = mk_res(KIND_FRAME, b, 1'b0, ST_OK);
					if (left_new == 5'd0) begin
						res_list.ent[1] = mk_res(KIND_FRAME, 8'h00 - sum_new, 1'b0, ST_OK);
						res_list.ent[2] = mk_res(KIND_FRAME, POSTAMBLE, 1'b1, ST_OK);
						res_list.count  = CNT_W'(3);
					end else begin
						res_list.count  = CNT_W'(1);
					end
				end
			end
			MODE_ACK: begin
				ack_index_nxt = aidx;
				ack_error_nxt = aerr;
				if (aidx < ACK_LEN) begin
					ack_index_nxt = aidx + 3'd1;
					ack_error_nxt = aerr | (b != ack_byte(aidx));
					if (aidx + 3'd1 == ACK_LEN) begin
						res_list.ent[0] = mk_res(KIND_ACK_STATUS, 8'h00, 1'b0,
							(aerr | (b != ack_byte(aidx))) ? ST_ACK_MISMATCH : ST_OK);
						res_list.count  = CNT_W'(1);
					end
				end
			end
			MODE_REPLY: begin
				reply_index_nxt = ridx;
				reply_done_nxt  = rdone;
				if (item.frame_start)
					capacity_held_nxt = item.reply_capacity;
				if (!rdone) begin
					reply_index_nxt = ridx + 6'd1;
					case (ridx)
						RIDX_READY: begin
							if (!b[0]) begin
								fail    = 1'b1;
								fail_st = ST_BAD_START;
							end
						end
						RIDX_PRE0, RIDX_PRE1: begin
							if (b != PREAMBLE) begin
								fail    = 1'b1;
								fail_st = ST_BAD_START;
							end
						end
						RIDX_START: begin
							if (b != START_CODE) begin
								fail    = 1'b1;
								fail_st = ST_BAD_START;
							end
						end
						RIDX_LEN: begin
							reply_length_nxt = b;
						end
						RIDX_LCS: begin
							if ((reply_length_q + b) != 8'h00 || reply_length_q < LEN_EXTRA
								|| (10'(reply_length_q) + 10'd8) > 10'(REPLY_FRAME_BYTES)) begin
								fail    = 1'b1;
								fail_st = ST_BAD_HEADER;
							end
						end
						RIDX_TFI: begin
							if (b != TFI_READER) begin
								fail    = 1'b1;
								fail_st = ST_BAD_HEADER;
							end
						end
						RIDX_CODE: begin
							if (b != last_command_q + 8'd1) begin
								fail    = 1'b1;
								fail_st = ST_BAD_HEADER;
							end else if (dl > 8'(capacity_held_nxt)) begin
								fail    = 1'b1;
								fail_st = ST_OVER_CAP;
							end else if (dl == 8'd0) begin
								res_list.ent[0] = mk_res(KIND_REPLY_STATUS, 8'h00, 1'b0, ST_OK);
								res_list.count  = CNT_W'(1);
								reply_done_nxt  = 1'b1;
							end
						end
						default: begin
							// Payload byte; the final one is followed by the length status.
							if ((8'(ridx) - 8'd7) >= dl) begin
								res_list.ent[0] = mk_res(KIND_DATA, b, 1'b1, ST_OK);
								res_list.ent[1] = mk_res(KIND_REPLY_STATUS, dl, 1'b0, ST_OK);
								res_list.count  = CNT_W'(2);
								reply_done_nxt  = 1'b1;
							end else begin
								res_list.ent[0] = mk_res(KIND_DATA, b, 1'b0, ST_OK);
								res_list.count  = CNT_W'(1);
							end
						end
					endcase
					if (fail) begin
						res_list.ent[0] = mk_res(KIND_REPLY_STATUS, 8'h00, 1'b0, fail_st);
						res_list.count  = CNT_W'(1);
						reply_done_nxt  = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_command_q  <= '0;
			data_sum_q      <= '0;
			params_left_q   <= '0;
			ack_index_q     <= '0;
			ack_error_q     <= 1'b0;
			reply_index_q   <= '0;
			reply_length_q  <= '0;
			capacity_held_q <= '0;
			reply_done_q    <= 1'b1;
		end else if (fire) begin
			last_command_q  <= last_command_nxt;
			data_sum_q      <= data_sum_nxt;
			params_left_q   <= params_left_nxt;
			ack_index_q     <= ack_index_nxt;
			ack_error_q     <= ack_error_nxt;
			reply_index_q   <= reply_index_nxt;
			reply_length_q  <= reply_length_nxt;
			capacity_held_q <= capacity_held_nxt;
			reply_done_q    <= reply_done_nxt;
		end
	end

	a_ack_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		ack_index_q <= ACK_LEN)
		else $error("ack index ran past the acknowledge frame");

	a_params_left_range: assert property (@(posedge clk) disable iff (!arst_n)
		(10'(params_left_q) + 10'd9) <= 10'(CMD_FRAME_BYTES))
		else $error("parameter count exceeds the command frame");

	a_payload_checked: assert property (@(posedge clk) disable iff (!arst_n)
		(!reply_done_q && reply_index_q > RIDX_CODE) |->
			(reply_length_q >= LEN_EXTRA && dl <= 8'(capacity_held_q)))
		else $error("reply payload in progress without a validated length");

endmodule

### design/nfc_codec_queue.sv
// Result register: holds the result list of one item and hands it out one transfer at a time.
// Depends on nfc_codec_pkg.
module nfc_codec_queue (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     load,
	input  nfc_codec_pkg::res_list_t res_list,
	output logic                     ready,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [1:0]               kind,
	output logic [7:0]               out_byte,
	output logic                     last,
	output logic [2:0]               status
);
	import nfc_codec_pkg::*;

	logic [CNT_W-1:0] cnt_q;
	res_t             ent_q [MAX_RESULTS];
	logic             take;

	assign out_valid = cnt_q != '0;
	assign take      = out_valid && !out_stall;
	// A new list may enter once the current one is empty or its final entry leaves now.
	assign ready     = (cnt_q == '0) || (cnt_q == CNT_W'(1) && take);

	assign kind     = ent_q[0].kind;
	assign out_byte = ent_q[0].out_byte;
	assign last     = ent_q[0].last;
	assign status   = ent_q[0].status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= res_list.count;
		end else if (take) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int k = 0; k < MAX_RESULTS; k++)
				ent_q[k] <= res_list.ent[k];
		end else if (take) begin
			for (int k = 0; k < MAX_RESULTS - 1; k++)
				ent_q[k] <= ent_q[k + 1];
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_RESULTS))
		else $error("result count out of range");

	a_postamble_final: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last && ent_q[0].kind == KIND_FRAME) |-> cnt_q == CNT_W'(1))
		else $error("results pending behind the postamble");

	a_data_end_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last && ent_q[0].kind == KIND_DATA) |->
			(cnt_q >= CNT_W'(2) && ent_q[1].kind == KIND_REPLY_STATUS))
		else $error("final data byte not followed by the reply status");

	a_data_status_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && ent_q[0].kind == KIND_DATA) |-> ent_q[0].status == ST_OK)
		else $error("data byte carries an error status");

endmodule

### verif/tb_nfc_host_frame_codec.sv
// Self-checking testbench for nfc_host_frame_codec: command frames, acknowledge and reply reads.
// A scoreboard class predicts every result transfer from the accepted items and checks the outputs.
// Depends on nfc_codec_pkg and the nfc_host_frame_codec RTL.
module tb_nfc_host_frame_codec;
	timeunit 1ns;
	timeprecision 1ps;

	import nfc_codec_pkg::*;

	localparam logic [47:0] ACK_SEQ = 48'h01_00_00_FF_00_FF;
	localparam int QUIET_LIMIT = 3000;

	typedef enum int {
		FAULT_NONE,
		FAULT_READY,
		FAULT_PRE,
		FAULT_LEN,
		FAULT_LCS,
		FAULT_TFI,
		FAULT_CODE,
		FAULT_CAP
	} fault_t;

	class codec_checker;
		logic [7:0] last_cmd;
		logic [7:0] running_sum;
		logic [4:0] params_left;
		logic [2:0] ack_pos;
		logic       ack_bad;
		logic [5:0] reply_pos;
		logic [7:0] reply_len;
		logic [4:0] cap_held;
		logic       reply_idle;
		res_t       due_results[$];
		int         errors;
		int         accepted;

		function new();
			last_cmd    = '0;
			running_sum = '0;
			params_left = '0;
			ack_pos     = '0;
			ack_bad     = 1'b0;
			reply_pos   = '0;
			reply_len   = '0;
			cap_held    = '0;
			reply_idle  = 1'b1;
			errors      = 0;
			accepted    = 0;
		endfunction

		function void push(kind_t k, logic [7:0] b, logic l, status_t s);
			res_t r;
			r.kind     = k;
			r.out_byte = b;
			r.last     = l;
			r.status   = s;
			due_results.push_back(r);
		endfunction

		// Trailer of a command frame: data checksum, then the postamble.
		function void close_command();
			push(KIND_FRAME, 8'h00 - running_sum, 1'b0, ST_OK);
			push(KIND_FRAME, POSTAMBLE, 1'b1, ST_OK);
		endfunction

		function void end_reply(status_t s);
			push(KIND_REPLY_STATUS, 8'h00, 1'b0, s);
			reply_idle = 1'b1;
		endfunction

		// Updates the codec state for one accepted item and queues the results it causes.
		function void derive_results(item_t it);
			logic [7:0] len;
			logic [7:0] dlen;
			logic [7:0] lsum;
			logic [5:0] pos;
			accepted++;
			case (it.mode)
				MODE_CMD: begin
					last_cmd = it.command_code;
					if (int'(it.param_count) + 9 > CMD_FRAME_BYTES) begin
						params_left = '0;
						push(KIND_FRAME, 8'h00, 1'b0, ST_TOO_MANY);
					end else begin
						len = 8'(it.param_count) + 8'd2;
						push(KIND_FRAME, PREAMBLE, 1'b0, ST_OK);
						push(KIND_FRAME, PREAMBLE, 1'b0, ST_OK);
						push(KIND_FRAME, START_CODE, 1'b0, ST_OK);
						push(KIND_FRAME, len, 1'b0, ST_OK);
						push(KIND_FRAME, 8'h00 - len, 1'b0, ST_OK);
						push(KIND_FRAME, TFI_HOST, 1'b0, ST_OK);
						push(KIND_FRAME, it.command_code, 1'b0, ST_OK);
						running_sum = TFI_HOST + it.command_code;
						params_left = it.param_count;
						if (it.param_count == 0)
							close_command();
					end
				end
				MODE_PARAM: begin
					if (params_left == 0)
						return;
					push(KIND_FRAME, it.data_byte, 1'b0, ST_OK);
					running_sum = running_sum + it.data_byte;
					params_left = params_left - 5'd1;
					if (params_left == 0)
						close_command();
				end
				MODE_ACK: begin
					if (it.frame_start) begin
						ack_pos = '0;
						ack_bad = 1'b0;
					end
					if (ack_pos >= 3'd6)
						return;
					if (it.data_byte != ACK_SEQ[47 - 8 * int'(ack_pos) -: 8])
						ack_bad = 1'b1;
					ack_pos = ack_pos + 3'd1;
					if (ack_pos == 3'd6)
						push(KIND_ACK_STATUS, 8'h00, 1'b0, ack_bad ? ST_ACK_MISMATCH : ST_OK);
				end
				default: begin
					if (it.frame_start) begin
						reply_pos  = '0;
						reply_idle = 1'b0;
						cap_held   = it.reply_capacity;
					end
					if (reply_idle)
						return;
					pos       = reply_pos;
					dlen      = reply_len - 8'd2;
					reply_pos = reply_pos + 6'd1;
					case (pos)
						RIDX_READY: if (!it.data_byte[0]) end_reply(ST_BAD_START);
						RIDX_PRE0, RIDX_PRE1: if (it.data_byte != PREAMBLE) end_reply(ST_BAD_START);
						RIDX_START: if (it.data_byte != START_CODE) end_reply(ST_BAD_START);
						RIDX_LEN: reply_len = it.data_byte;
						RIDX_LCS: begin
							lsum = reply_len + it.data_byte;
							if (lsum != 8'h00 || reply_len < 8'd2 ||
									int'(reply_len) + 8 > REPLY_FRAME_BYTES)
								end_reply(ST_BAD_HEADER);
						end
						RIDX_TFI: if (it.data_byte != TFI_READER) end_reply(ST_BAD_HEADER);
						RIDX_CODE: begin
							if (it.data_byte != last_cmd + 8'd1)
								end_reply(ST_BAD_HEADER);
							else if (dlen > 8'(cap_held))
								end_reply(ST_OVER_CAP);
							else if (dlen == 0)
								end_reply(ST_OK);
						end
						default: begin
							if (int'(pos) - 7 >= int'(dlen)) begin
								push(KIND_DATA, it.data_byte, 1'b1, ST_OK);
								push(KIND_REPLY_STATUS, dlen, 1'b0, ST_OK);
								reply_idle = 1'b1;
							end else begin
								push(KIND_DATA, it.data_byte, 1'b0, ST_OK);
							end
						end
					endcase
				end
			endcase
		endfunction

		function void match_result(logic [1:0] k, logic [7:0] b, logic l, logic [2:0] s);
			res_t want;
			if (due_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: kind %0d byte %02h last %0b status %0d",
						k, b, l, s);
				return;
			end
			want = due_results.pop_front();
			if (want.kind !== k || want.out_byte !== b || want.last !== l || want.status !== s) begin
				errors++;
				if (errors <= 10)
					$display({"result mismatch: expected kind %0d byte %02h last %0b status %0d,",
						" got kind %0d byte %02h last %0b status %0d"},
						want.kind, want.out_byte, want.last, want.status, k, b, l, s);
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [1:0] mode = '0;
	logic [7:0] data_byte = '0;
	logic [7:0] command_code = '0;
	logic [4:0] param_count = '0;
	logic       frame_start = 1'b0;
	logic [4:0] reply_capacity = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [1:0] kind;
	logic [7:0] out_byte;
	logic       last;
	logic [2:0] status;

	codec_checker sb = new();
	logic [7:0]   cmd_issued = '0;
	bit           quiet_in = 1'b0;
	bit           calm_out = 1'b0;
	int           stall_hold = 0;

	nfc_host_frame_codec uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.data_byte(data_byte),
		.command_code(command_code),
		.param_count(param_count),
		.frame_start(frame_start),
		.reply_capacity(reply_capacity),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.out_byte(out_byte),
		.last(last),
		.status(status)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		item_t it;
		if (arst_n && in_valid && !in_stall) begin
			it.mode           = mode;
			it.data_byte      = data_byte;
			it.command_code   = command_code;
			it.param_count    = param_count;
			it.frame_start    = frame_start;
			it.reply_capacity = reply_capacity;
			sb.derive_results(it);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.match_result(kind, out_byte, last, status);
	end

	// Receiver back-pressure: mostly short stalls, a few long ones, and calm stretches.
	always @(posedge clk) begin
		int r;
		if (stall_hold != 0) begin
			stall_hold <= stall_hold - 1;
		end else begin
			r = $urandom_range(0, 99);
			if ($urandom_range(0, 49) == 0)
				calm_out <= !calm_out;
			if (calm_out || r < 70) begin
				out_stall  <= 1'b0;
				stall_hold <= $urandom_range(0, 4);
			end else begin
				out_stall  <= 1'b1;
				stall_hold <= (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 50);
			end
		end
	end

	initial begin : watchdog
		int still_cycles;
		still_cycles = 0;
		while (still_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
				still_cycles = 0;
			else
				still_cycles++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		if (quiet_in)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Drives one item and returns at the edge where its transfer takes place.
	task automatic send_item(mode_t m, logic [7:0] b, logic [7:0] cmd, logic [4:0] cnt,
			logic st, logic [4:0] cap);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid       <= 1'b1;
		mode           <= m;
		data_byte      <= b;
		command_code   <= cmd;
		param_count    <= cnt;
		frame_start    <= st;
		reply_capacity <= cap;
		if (m == MODE_CMD)
			cmd_issued = cmd;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic issue_command(logic [7:0] cmd, logic [4:0] cnt, int nparams);
		send_item(MODE_CMD, 8'($urandom), cmd, cnt, 1'($urandom), 5'($urandom));
		for (int i = 0; i < nparams; i++)
			send_item(MODE_PARAM, 8'($urandom), 8'($urandom), 5'($urandom),
				1'($urandom), 5'($urandom));
	endtask

	// Sends nbytes acknowledge bytes; bytes past the sixth are random and the one at bad_pos is corrupted.
	task automatic ack_read(logic st, int nbytes, int bad_pos);
		logic [7:0] b;
		for (int i = 0; i < nbytes; i++) begin
			b = (i < 6) ? ACK_SEQ[47 - 8 * i -: 8] : 8'($urandom);
			if (i == bad_pos)
				b = b ^ 8'($urandom_range(1, 255));
			send_item(MODE_ACK, b, 8'($urandom), 5'($urandom), (i == 0) ? st : 1'b0,
				5'($urandom));
		end
	endtask

	// Builds a reply read with at most one fault, sends it up to the byte that ends
	// the read, then adds some trailing bytes that the codec has to ignore.
	task automatic reply_read(fault_t f, int dlen, int extra);
		logic [7:0] frame[$];
		logic [7:0] len;
		logic [4:0] cap;
		int         stop;
		if (f == FAULT_CAP && dlen == 0)
			dlen = 1;
		cap = (f == FAULT_CAP) ? 5'($urandom_range(0, dlen - 1)) : 5'($urandom_range(dlen, 31));
		len = 8'(dlen + 2);
		if (f == FAULT_LEN)
			len = $urandom_range(0, 1) ? 8'($urandom_range(0, 1)) : 8'($urandom_range(33, 255));
		frame.push_back(8'($urandom) | 8'h01);
		frame.push_back(PREAMBLE);
		frame.push_back(PREAMBLE);
		frame.push_back(START_CODE);
		frame.push_back(len);
		frame.push_back((f == FAULT_LCS) ? 8'h00 - len + 8'($urandom_range(1, 255))
			: 8'h00 - len);
		frame.push_back((f == FAULT_TFI) ? TFI_READER ^ 8'($urandom_range(1, 255)) : TFI_READER);
		frame.push_back((f == FAULT_CODE) ? cmd_issued + 8'd1 + 8'($urandom_range(1, 255))
			: cmd_issued + 8'd1);
		for (int i = 0; i < dlen; i++)
			frame.push_back(8'($urandom));
		case (f)
			FAULT_NONE: stop = frame.size();
			FAULT_READY: begin
				frame[0] = frame[0] & 8'hFE;
				stop = 1;
			end
			FAULT_PRE: begin
				stop = $urandom_range(1, 3);
				frame[stop] = frame[stop] ^ 8'($urandom_range(1, 255));
				stop = stop + 1;
			end
			FAULT_LEN, FAULT_LCS: stop = 6;
			FAULT_TFI: stop = 7;
			default: stop = 8;
		endcase
		for (int i = 0; i < stop + extra; i++)
			send_item(MODE_REPLY, (i < stop) ? frame[i] : 8'($urandom), 8'($urandom),
				5'($urandom), (i == 0), cap);
	endtask

	initial begin : main_seq
		int     pick;
		int     cnt;
		int     np;
		mode_t  noise_mode;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Acknowledge bytes are taken without a start right after reset,
		// and a seventh byte is dropped.
		ack_read(1'b0, 7, -1);
		// A reply byte with no read in progress and a stray parameter byte are both ignored.
		send_item(MODE_REPLY, 8'h01, 8'h00, 5'd0, 1'b0, 5'd31);
		send_item(MODE_PARAM, 8'hA5, 8'hFF, 5'd31, 1'b1, 5'd0);
		issue_command(8'hFF, 5'd24, 0);
		issue_command(8'h00, 5'd31, 0);
		issue_command(8'h00, 5'd0, 0);
		issue_command(8'hFF, 5'd2, 2);
		reply_read(FAULT_READY, 0, 1);
		// The expected reply code wraps from 0xFF to 0x00 here.
		reply_read(FAULT_NONE, 0, 0);

		while (sb.accepted < 150) begin
			quiet_in = ($urandom_range(0, 4) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				np = $urandom_range(0, 99);
				cnt = (np < 8) ? $urandom_range(24, 31) :
					(np < 20) ? $urandom_range(7, 23) : $urandom_range(0, 6);
				np = (cnt > 23) ? 0 : cnt;
				if ($urandom_range(0, 9) == 0)
					np = $urandom_range(0, cnt + 1);
				issue_command(8'($urandom), 5'(cnt), np);
			end else if (pick < 50) begin
				ack_read($urandom_range(0, 9) != 0,
					($urandom_range(0, 9) == 0) ? $urandom_range(1, 8) : 6,
					($urandom_range(0, 2) == 0) ? $urandom_range(0, 5) : -1);
			end else if (pick < 88) begin
				reply_read(($urandom_range(0, 99) < 55) ? FAULT_NONE :
					fault_t'($urandom_range(1, 7)),
					($urandom_range(0, 4) == 0) ? $urandom_range(7, 30) : $urandom_range(0, 6),
					($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
			end else begin
				noise_mode = mode_t'($urandom_range(0, 3));
				send_item(noise_mode, 8'($urandom), 8'($urandom), 5'($urandom),
					1'($urandom), 5'($urandom));
			end
		end
		in_valid <= 1'b0;
		@(posedge clk);

		while (sb.due_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.due_results.size() != 0) begin
			sb.errors += sb.due_results.size();
			$display("%0d expected results never arrived", sb.due_results.size());
		end
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
